// File: src/bca_pkg.sv
`timescale 1ns / 1ps

package bca_pkg;

  // Pixel and register widths
  localparam int CH_W       = 8;
  localparam int ADJ_W      = 9;
  localparam int FRAC_BITS  = 16;
  localparam int FACTOR_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ADJ_W;

  // Contrast math widths: (c-128) is 9 bits signed, F is 24 bits unsigned
  localparam int PROD_W     = 34;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST = 2'd1;

  // Mode codes
  localparam logic MODE_BRIGHT   = 1'b0;
  localparam logic MODE_CONTRAST = 1'b1;

  // Levels and constants of the factor formula
  localparam logic [CH_W-1:0]     MAX_LEVEL = 8'd255;
  localparam logic signed [8:0]   MID_LEVEL = 9'sd128;
  localparam logic signed [PROD_W-1:0] MID_Q = 34'sd8388608;  // 128 in Q.16
  localparam logic [FACTOR_W-1:0] ONE_Q     = 24'h010000;
  localparam logic [8:0]          K_NUM     = 9'd259;
  localparam logic [7:0]          K_DEN     = 8'd255;

  // Divider: numerator 34 bits, quotient known to fit in 24 bits
  localparam int NUM_W   = 34;
  localparam int DEN_W   = 17;
  localparam int STEPS   = FACTOR_W;
  localparam int CNT_W   = $clog2(STEPS);

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  // Divider status toward the top level
  typedef struct packed {
    logic                busy;
    logic [FACTOR_W-1:0] factor;
  } div_stat_t;

  // Settings shared by the three channel lanes
  typedef struct packed {
    logic                    mode;
    logic signed [ADJ_W-1:0] adjust;
    logic [FACTOR_W-1:0]     factor;
  } lane_cfg_t;

endpackage

// File: src/bca_factor_div.sv
`timescale 1ns / 1ps

module bca_factor_div
  import bca_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ADJ_W-1:0] adjust,
  output div_stat_t               stat
);

  div_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [FACTOR_W-1:0] shreg_r, shreg_nxt;   // numerator bits in, quotient bits out
  logic [FACTOR_W-1:0] factor_r, factor_nxt;

  // Setup terms of F = 259(a+255) * 2^16 / (255(259-a))
  logic signed [ADJ_W:0] a_sum;
  logic [ADJ_W:0]        a_diff;
  logic [17:0]           num_hi;
  logic [NUM_W-1:0]      num;
  logic [DEN_W-1:0]      den_new;

  // One restoring step
  logic [DEN_W:0]        trial;
  logic                  fits;

  assign a_sum   = $signed({adjust[ADJ_W-1], adjust}) + 10'sd255;
  assign a_diff  = 10'(K_NUM) - 10'($signed({adjust[ADJ_W-1], adjust}));
  assign num_hi  = 18'(K_NUM) * 18'(a_sum[8:0]);
  assign num     = {num_hi, {FRAC_BITS{1'b0}}};
  assign den_new = DEN_W'(K_DEN) * DEN_W'(a_diff);

  assign trial = {rem_r, shreg_r[FACTOR_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= DIV_IDLE;
      cnt_r    <= '0;
      factor_r <= ONE_Q;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      factor_r <= factor_nxt;
    end
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    shreg_r <= shreg_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    shreg_nxt  = shreg_r;
    factor_nxt = factor_r;

    unique case (state_r)
      DIV_IDLE: ;
      DIV_RUN: begin
        rem_nxt   = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        shreg_nxt = {shreg_r[FACTOR_W-2:0], fits};
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt  = DIV_IDLE;
          factor_nxt = {shreg_r[FACTOR_W-2:0], fits};
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase

    // A new adjust value restarts the division
    if (start) begin
      if (a_sum < 0) begin
        // negative factor saturates to zero
        state_nxt  = DIV_IDLE;
        factor_nxt = '0;
      end else begin
        state_nxt = DIV_RUN;
        cnt_nxt   = CNT_W'(STEPS - 1);
        den_nxt   = den_new;
        // top bits are below the divisor since the quotient fits 24 bits
        rem_nxt   = DEN_W'(num[NUM_W-1:FACTOR_W]);
        shreg_nxt = num[FACTOR_W-1:0];
      end
    end
  end

  assign stat.busy   = (state_r == DIV_RUN);
  assign stat.factor = factor_r;

endmodule

// File: src/bca_lane.sv
`timescale 1ns / 1ps

module bca_lane
  import bca_pkg::*;
(
  input  lane_cfg_t       cfg,
  input  logic [CH_W-1:0] c_in,
  output logic [CH_W-1:0] c_out
);

  logic signed [ADJ_W:0]    bsum;
  logic signed [8:0]        dc;
  logic signed [FACTOR_W:0] fs;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] t;
  logic [CH_W-1:0]          bright;
  logic [CH_W-1:0]          contr;

  // Brightness: add offset, saturate
  assign bsum = $signed({2'b00, c_in}) + $signed({cfg.adjust[ADJ_W-1], cfg.adjust});

  always_comb begin
    if (bsum < 0)
      bright = '0;
    else if (bsum > $signed({2'b00, MAX_LEVEL}))
      bright = MAX_LEVEL;
    else
      bright = bsum[CH_W-1:0];
  end

  // Contrast: (c-128)*F + 128, floor, saturate
  assign dc   = $signed({1'b0, c_in}) - MID_LEVEL;
  assign fs   = $signed({1'b0, cfg.factor});
  assign prod = PROD_W'(dc) * PROD_W'(fs);
  assign t    = prod + MID_Q;

  always_comb begin
    if (t[PROD_W-1])
      contr = '0;
    else if (t[PROD_W-2:FRAC_BITS+CH_W] != '0)
      contr = MAX_LEVEL;
    else
      contr = t[FRAC_BITS+CH_W-1:FRAC_BITS];
  end

  assign c_out = (cfg.mode == MODE_CONTRAST) ? contr : bright;

endmodule

// File: src/rgb_brightness_contrast_adjust.sv
`timescale 1ns / 1ps
// Channel  Ports                                   Moves
// in       in_valid/in_ready, in_{red,green,blue}_in    one RGB888 pixel
// out      out_valid/out_ready, out_{red,green,blue}_out one adjusted pixel
// cfg      cfg_we, cfg_index, cfg_wdata            mode / adjust register write
//
// One pixel per clock when out_ready is high and the divider is idle.
// Path: input register, result register. Writing adjust runs a restoring
// divider for the contrast factor, with in_ready low; adjust -256 zeroes it.
// Reset (synchronous, rst_n low) gives mode brightness, adjust 0, factor 1.0.
// Stalls on out_ready back up through both registers without losing an item.

module rgb_brightness_contrast_adjust
  import bca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_W-1:0]       in_red_in,
  input  logic [CH_W-1:0]       in_green_in,
  input  logic [CH_W-1:0]       in_blue_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_red_out,
  output logic [CH_W-1:0]       out_green_out,
  output logic [CH_W-1:0]       out_blue_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                    mode_r, mode_nxt;
  logic signed [ADJ_W-1:0] adjust_r, adjust_nxt;
  logic                    div_start;
  div_stat_t               div_stat;
  lane_cfg_t               lane_cfg;

  logic                    s1_valid_r;
  logic [CH_W-1:0]         s1_red_r, s1_green_r, s1_blue_r;
  logic                    s1_go;
  logic                    out_valid_r;
  logic [CH_W-1:0]         out_red_r, out_green_r, out_blue_r;
  logic [CH_W-1:0]         red_adj, green_adj, blue_adj;

  // Register writes
  always_comb begin
    mode_nxt   = mode_r;
    adjust_nxt = adjust_r;
    div_start  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode_nxt = cfg_wdata[0];
        REG_ADJUST: begin
          adjust_nxt = $signed(cfg_wdata[ADJ_W-1:0]);
          div_start  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BRIGHT;
      adjust_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      adjust_r <= adjust_nxt;
    end
  end

  // Contrast factor
  bca_factor_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .adjust (adjust_nxt),
    .stat   (div_stat)
  );

  assign lane_cfg.mode   = mode_r;
  assign lane_cfg.adjust = adjust_r;
  assign lane_cfg.factor = div_stat.factor;

  // Handshake: stage 1 moves when the result register is free or drained
  assign s1_go    = !out_valid_r || out_ready;
  assign in_ready = !div_stat.busy && (!s1_valid_r || s1_go);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_valid_r <= 1'b0;
    else if (in_ready)
      s1_valid_r <= in_valid;
    else if (s1_go)
      s1_valid_r <= 1'b0;
    if (in_ready && in_valid) begin
      s1_red_r   <= in_red_in;
      s1_green_r <= in_green_in;
      s1_blue_r  <= in_blue_in;
    end
  end

  // Channel lanes
  bca_lane u_red   (.cfg(lane_cfg), .c_in(s1_red_r),   .c_out(red_adj));
  bca_lane u_green (.cfg(lane_cfg), .c_in(s1_green_r), .c_out(green_adj));
  bca_lane u_blue  (.cfg(lane_cfg), .c_in(s1_blue_r),  .c_out(blue_adj));

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (s1_go)
      out_valid_r <= s1_valid_r;
    if (s1_go && s1_valid_r) begin
      out_red_r   <= red_adj;
      out_green_r <= green_adj;
      out_blue_r  <= blue_adj;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;

  // Checks
  a_neg_factor: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_ADJUST && cfg_wdata == 9'h100)
      |=> (div_stat.factor == '0 && !div_stat.busy))
    else $error("factor not cleared for adjust -256");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_ADJUST && cfg_wdata != 9'h100) |=> div_stat.busy)
    else $error("divider did not start on adjust write");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_red_r)
      && $stable(s1_green_r) && $stable(s1_blue_r)))
    else $error("stalled input register lost its item");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted item not held in input register");

endmodule
